/* rtl/xoshiro128pp_random_generator_macros.svh */
// Assertion macros for the xoshiro128++ random generator.
`ifndef XOSHIRO128PP_RANDOM_GENERATOR_MACROS_SVH
`define XOSHIRO128PP_RANDOM_GENERATOR_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every clock edge while the block is out of reset.
`define XRG_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("xoshiro128pp assertion failed");

// Checked on every clock edge, reset included.
`define XRG_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("xoshiro128pp assertion failed");

`else

`define XRG_ASSERT(label, prop)
`define XRG_ASSERT_ALWAYS(label, prop)

`endif

`endif

/* rtl/xoshiro_pkg.sv */
// Package with the constants, command codes, state type and helpers of the generator.
package xoshiro_pkg;

    // Seed expansion constants.
    localparam logic [31:0] GOLD32 = 32'h9E3779B9;
    localparam logic [31:0] MIX32A = 32'h21F0AAAD;
    localparam logic [31:0] MIX32B = 32'h735A2D97;
    localparam logic [63:0] GOLD64 = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] MIX64A = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] MIX64B = 64'h94D049BB133111EB;

    // Command codes carried in tuser.
    typedef logic [1:0] cmd_t;
    localparam cmd_t CMD_DRAW   = 2'd0;
    localparam cmd_t CMD_SEED32 = 2'd1;
    localparam cmd_t CMD_SEED64 = 2'd2;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_STEP,
        ST_MUL,
        ST_FIX
    } state_t;

    // Rotate left by a constant amount.
    function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned k);
        return (v << k) | (v >> (32 - k));
    endfunction

    // The xoshiro128++ output word, taken before the state advances.
    function automatic logic [31:0] draw_output(input logic [31:0] s0, input logic [31:0] s3);
        return rotl32(s0 + s3, 7) + s0;
    endfunction

endpackage

/* rtl/xoshiro128pp_random_generator.sv */
// Top level of the xoshiro128++ random word generator with splitmix seeding.
// The word of a draw appears in the output register in the cycle after the draw is taken;
// draws run at one item per cycle while the output side keeps up.
// Seeding uses the shared 32x32 multiplier; a mix round of a 64-bit seed sums three
// partial products, while a 32-bit seed needs a single product per round.
// After reset the block runs the 32-bit expansion of seed zero before it is ready.
`include "xoshiro128pp_random_generator_macros.svh"

module xoshiro128pp_random_generator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // [63:0] seed_value
    input  logic [1:0]  s_tuser,    // [1:0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata     // [31:0] random_word
);

    xoshiro_pkg::state_t fsm_reg, fsm_next;

    logic [31:0] gs_reg [4];
    logic [31:0] gs_next [4];
    logic [63:0] x_reg, x_next;
    logic [63:0] t_reg, t_next;
    logic [63:0] p_reg, p_next;
    logic [63:0] acc_reg, acc_next;
    logic [1:0]  phase_reg, phase_next;
    logic [1:0]  word_reg, word_next;
    logic        round_reg, round_next;
    logic        wide_reg, wide_next;
    logic [31:0] out_reg, out_next;
    logic        out_valid_reg, out_valid_next;

    logic        in_fire, out_fire;
    logic [63:0] mul_const;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [63:0] mix_res, mix_fb, mix_out64;
    logic [31:0] mix_word;
    logic        mix_last;
    logic [31:0] step32;
    logic [63:0] step64;
    logic [31:0] d_t, d_s2, d_s3;

    // Handshakes.
    assign s_tready = (fsm_reg == xoshiro_pkg::ST_IDLE) && (!out_valid_reg || m_tready);
    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = out_valid_reg && m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    // Shared multiplier: picks the halves of the operand and constant by phase.
    always_comb begin
        if (wide_reg) begin
            mul_const = round_reg ? xoshiro_pkg::MIX64B : xoshiro_pkg::MIX64A;
        end else begin
            mul_const = {32'b0, (round_reg ? xoshiro_pkg::MIX32B : xoshiro_pkg::MIX32A)};
        end
        mul_a = (phase_reg == 2'd2) ? t_reg[63:32] : t_reg[31:0];
        mul_b = (phase_reg == 2'd1) ? mul_const[63:32] : mul_const[31:0];
        mul_p = {32'b0, mul_a} * {32'b0, mul_b};
    end

    // Finishing of one mix round from the registered partial products.
    always_comb begin
        if (wide_reg) begin
            mix_res   = {acc_reg[63:32] + p_reg[31:0], acc_reg[31:0]};
            mix_last  = (phase_reg == 2'd3);
            mix_fb    = mix_res ^ (mix_res >> 27);
            mix_out64 = mix_res ^ (mix_res >> 31);
        end else begin
            mix_res   = {32'b0, p_reg[31:0]};
            mix_last  = (phase_reg == 2'd1);
            mix_fb    = {32'b0, p_reg[31:0] ^ (p_reg[31:0] >> 15)};
            mix_out64 = mix_fb;
        end
        mix_word = mix_out64[31:0];
    end

    // Counter advance for the next seed word.
    assign step32 = x_reg[31:0] + xoshiro_pkg::GOLD32;
    assign step64 = x_reg + xoshiro_pkg::GOLD64;

    // Intermediate terms of one xoshiro128++ step.
    assign d_t  = gs_reg[1] << 9;
    assign d_s2 = gs_reg[2] ^ gs_reg[0];
    assign d_s3 = gs_reg[3] ^ gs_reg[1];

    // Next state of the sequencer.
    always_comb begin
        fsm_next = fsm_reg;
        case (fsm_reg)
            xoshiro_pkg::ST_IDLE: begin
                if (in_fire && (s_tuser inside {xoshiro_pkg::CMD_SEED32,
                                                xoshiro_pkg::CMD_SEED64})) begin
                    fsm_next = xoshiro_pkg::ST_STEP;
                end
            end
            xoshiro_pkg::ST_STEP: begin
                fsm_next = xoshiro_pkg::ST_MUL;
            end
            xoshiro_pkg::ST_MUL: begin
                if (mix_last && round_reg) begin
                    fsm_next = (word_reg == 2'd3) ? xoshiro_pkg::ST_FIX
                                                  : xoshiro_pkg::ST_STEP;
                end
            end
            xoshiro_pkg::ST_FIX: begin
                fsm_next = xoshiro_pkg::ST_IDLE;
            end
            default: begin
                fsm_next = xoshiro_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and output register updates.
    always_comb begin
        gs_next        = gs_reg;
        x_next         = x_reg;
        t_next         = t_reg;
        p_next         = p_reg;
        acc_next       = acc_reg;
        phase_next     = phase_reg;
        word_next      = word_reg;
        round_next     = round_reg;
        wide_next      = wide_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (out_fire) begin
            out_valid_next = 1'b0;
        end

        case (fsm_reg)
            xoshiro_pkg::ST_IDLE: begin
                if (in_fire) begin
                    case (s_tuser)
                        xoshiro_pkg::CMD_DRAW: begin
                            out_next       = xoshiro_pkg::draw_output(gs_reg[0], gs_reg[3]);
                            out_valid_next = 1'b1;
                            gs_next[0]     = gs_reg[0] ^ d_s3;
                            gs_next[1]     = gs_reg[1] ^ d_s2;
                            gs_next[2]     = d_s2 ^ d_t;
                            gs_next[3]     = xoshiro_pkg::rotl32(d_s3, 11);
                        end
                        xoshiro_pkg::CMD_SEED32: begin
                            x_next    = {32'b0, s_tdata[31:0] + xoshiro_pkg::GOLD32};
                            wide_next = 1'b0;
                            word_next = 2'd0;
                        end
                        xoshiro_pkg::CMD_SEED64: begin
                            x_next    = s_tdata + xoshiro_pkg::GOLD64;
                            wide_next = 1'b1;
                            word_next = 2'd0;
                        end
                        default: begin
                            // The unused code leaves everything as it is.
                        end
                    endcase
                end
            end
            xoshiro_pkg::ST_STEP: begin
                if (wide_reg) begin
                    x_next = step64;
                    t_next = step64 ^ (step64 >> 30);
                end else begin
                    x_next = {32'b0, step32};
                    t_next = {32'b0, step32 ^ (step32 >> 16)};
                end
                round_next = 1'b0;
                phase_next = 2'd0;
            end
            xoshiro_pkg::ST_MUL: begin
                p_next = mul_p;
                // Fold the partial products of a 64-bit multiply into the accumulator.
                if (phase_reg == 2'd1) begin
                    acc_next = p_reg;
                end else if (phase_reg == 2'd2) begin
                    acc_next[63:32] = acc_reg[63:32] + p_reg[31:0];
                end
                if (mix_last) begin
                    phase_next = 2'd0;
                    if (!round_reg) begin
                        t_next     = mix_fb;
                        round_next = 1'b1;
                    end else begin
                        gs_next[word_reg] = mix_word;
                        word_next         = word_reg + 2'd1;
                    end
                end else begin
                    phase_next = phase_reg + 2'd1;
                end
            end
            xoshiro_pkg::ST_FIX: begin
                if ((gs_reg[0] | gs_reg[1] | gs_reg[2] | gs_reg[3]) == 32'b0) begin
                    gs_next[0] = 32'd1;
                end
            end
            default: begin
            end
        endcase
    end

    // Control registers; reset starts the expansion of seed zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg       <= xoshiro_pkg::ST_STEP;
            x_reg         <= {32'b0, xoshiro_pkg::GOLD32};
            wide_reg      <= 1'b0;
            word_reg      <= 2'd0;
            phase_reg     <= 2'd0;
            round_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            fsm_reg       <= fsm_next;
            x_reg         <= x_next;
            wide_reg      <= wide_next;
            word_reg      <= word_next;
            phase_reg     <= phase_next;
            round_reg     <= round_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        gs_reg  <= gs_next;
        t_reg   <= t_next;
        p_reg   <= p_next;
        acc_reg <= acc_next;
        out_reg <= out_next;
    end

    // Checks on the sequencer and the output register.
    `XRG_ASSERT(busy_not_ready, (fsm_reg != xoshiro_pkg::ST_IDLE) |-> !s_tready)
    `XRG_ASSERT(draw_gives_item,
        (in_fire && (s_tuser == xoshiro_pkg::CMD_DRAW)) |=> m_tvalid)
    `XRG_ASSERT(seed_state_nonzero,
        (fsm_reg == xoshiro_pkg::ST_FIX) |=> ((gs_reg[0] | gs_reg[1] | gs_reg[2] | gs_reg[3]) != 32'b0))
    `XRG_ASSERT(narrow_two_phases,
        ((fsm_reg == xoshiro_pkg::ST_MUL) && !wide_reg) |-> (phase_reg <= 2'd1))
    `XRG_ASSERT_ALWAYS(reset_clears_output, !aresetn |=> !m_tvalid)

endmodule

/* dv/xoshiro128pp_random_generator_tb.sv */
// Testbench for the xoshiro128++ random word generator: directed and random commands, scoreboard.
`timescale 1ns / 1ps

module xoshiro128pp_random_generator_tb;

    // The command code that the block ignores.
    localparam xoshiro_pkg::cmd_t CMD_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS   = 1000;
    localparam int QUIET_ITEMS    = 150;
    localparam int DRAIN_CYCLES   = 60;
    localparam int WATCHDOG_LIMIT = 1000;

    // Predicts the output words of the generator and checks them in order.
    class word_scoreboard;
        logic [31:0] gen_words [4];
        logic [31:0] pending_words [$];
        int errors;
        int draws;
        int seeds32;
        int seeds64;
        int ignored;
        int words_checked;

        function new();
            errors        = 0;
            draws         = 0;
            seeds32       = 0;
            seeds64       = 0;
            ignored       = 0;
            words_checked = 0;
            // Out of reset the state holds the narrow expansion of seed zero.
            reseed_narrow(32'd0);
        endfunction

        // Splitmix32-style expansion of a 32-bit seed into the four state words.
        function void reseed_narrow(logic [31:0] seed);
            logic [31:0] x;
            logic [31:0] z;
            x = seed + xoshiro_pkg::GOLD32;
            for (int i = 0; i < 4; i++) begin
                x = x + xoshiro_pkg::GOLD32;
                z = x;
                z = (z ^ (z >> 16)) * xoshiro_pkg::MIX32A;
                z = (z ^ (z >> 15)) * xoshiro_pkg::MIX32B;
                gen_words[i] = z ^ (z >> 15);
            end
        endfunction

        // Called for each accepted input item.
        function void note_input(xoshiro_pkg::cmd_t cmd, logic [63:0] seed);
            logic [31:0] sum;
            logic [31:0] carry;
            logic [63:0] acc;
            logic [63:0] t;
            case (cmd)
                xoshiro_pkg::CMD_DRAW: begin
                    // Output word is taken before the state advances.
                    sum = gen_words[0] + gen_words[3];
                    pending_words.push_back({sum[24:0], sum[31:25]} + gen_words[0]);
                    carry = gen_words[1] << 9;
                    gen_words[2] ^= gen_words[0];
                    gen_words[3] ^= gen_words[1];
                    gen_words[1] ^= gen_words[2];
                    gen_words[0] ^= gen_words[3];
                    gen_words[2] ^= carry;
                    gen_words[3] = {gen_words[3][20:0], gen_words[3][31:21]};
                    draws++;
                end
                xoshiro_pkg::CMD_SEED32: begin
                    reseed_narrow(seed[31:0]);
                    seeds32++;
                end
                xoshiro_pkg::CMD_SEED64: begin
                    // Splitmix64, keeping the low half of each output.
                    acc = seed + xoshiro_pkg::GOLD64;
                    for (int i = 0; i < 4; i++) begin
                        acc = acc + xoshiro_pkg::GOLD64;
                        t = acc;
                        t = (t ^ (t >> 30)) * xoshiro_pkg::MIX64A;
                        t = (t ^ (t >> 27)) * xoshiro_pkg::MIX64B;
                        t = t ^ (t >> 31);
                        gen_words[i] = t[31:0];
                    end
                    seeds64++;
                end
                default: begin
                    ignored++;
                end
            endcase
            // A seed that leaves the state all zero gets a first word of one.
            if ((cmd == xoshiro_pkg::CMD_SEED32 || cmd == xoshiro_pkg::CMD_SEED64) &&
                (gen_words[0] | gen_words[1] | gen_words[2] | gen_words[3]) == 32'd0) begin
                gen_words[0] = 32'd1;
            end
        endfunction

        // Called for each accepted result item.
        function void check_word(logic [31:0] word);
            logic [31:0] want;
            words_checked++;
            if (pending_words.size() == 0) begin
                errors++;
                $error("random_word: result with no draw pending, actual %h", word);
                return;
            end
            want = pending_words.pop_front();
            if (word !== want) begin
                errors++;
                $error("random_word mismatch: expected %h, actual %h", want, word);
            end
        endfunction
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = 64'd0;
    logic [1:0]  s_tuser  = xoshiro_pkg::CMD_DRAW;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    word_scoreboard sb = new();

    int tx_idle_pct   = 15;
    int rx_idle_pct   = 15;
    int rx_stall_left = 0;
    int idle_cycles   = 0;

    xoshiro128pp_random_generator u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 100 MHz clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Output side: ready with random stall bursts.
    always @(negedge aclk) begin
        if (rx_stall_left > 0) begin
            rx_stall_left <= rx_stall_left - 1;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 99) < rx_idle_pct) begin
            rx_stall_left <= $urandom_range(1, 12) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Check every accepted result item.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_word(m_tdata);
        end
    end

    // Watchdog: stop the run if no item moves on either side for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles = idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no item accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Present one item, with an optional gap first, and wait until it is taken.
    task automatic drive_item(input xoshiro_pkg::cmd_t cmd, input logic [63:0] seed);
        int gap;
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            gap = $urandom_range(1, 12);
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= seed;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(cmd, seed);
        @(negedge aclk);
    endtask

    initial begin
        int produced;
        int pick;
        xoshiro_pkg::cmd_t cmd;
        logic [63:0] seed;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part: the reset state first.
        drive_item(xoshiro_pkg::CMD_DRAW, 64'd0);
        drive_item(xoshiro_pkg::CMD_DRAW, 64'hFFFF_FFFF_FFFF_FFFF);
        drive_item(xoshiro_pkg::CMD_DRAW, 64'd0);
        // Narrow seed of zero must ignore the upper half and restart the reset sequence.
        drive_item(xoshiro_pkg::CMD_SEED32, 64'hFFFF_FFFF_0000_0000);
        drive_item(xoshiro_pkg::CMD_DRAW, 64'd0);
        drive_item(xoshiro_pkg::CMD_DRAW, 64'd0);
        drive_item(xoshiro_pkg::CMD_SEED32, 64'h0000_0000_FFFF_FFFF);
        drive_item(xoshiro_pkg::CMD_DRAW, 64'd0);
        // Wide seeds at the extremes.
        drive_item(xoshiro_pkg::CMD_SEED64, 64'd0);
        drive_item(xoshiro_pkg::CMD_DRAW, 64'd0);
        drive_item(xoshiro_pkg::CMD_DRAW, 64'd0);
        drive_item(xoshiro_pkg::CMD_SEED64, 64'hFFFF_FFFF_FFFF_FFFF);
        drive_item(xoshiro_pkg::CMD_DRAW, 64'd0);
        drive_item(xoshiro_pkg::CMD_SEED64, 64'h8000_0000_0000_0000);
        drive_item(xoshiro_pkg::CMD_DRAW, 64'd0);
        // The unused code leaves the state alone.
        drive_item(CMD_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
        drive_item(xoshiro_pkg::CMD_DRAW, 64'd0);
        // Seeds back to back; only the last one counts.
        drive_item(xoshiro_pkg::CMD_SEED32, 64'h0123_4567_89AB_CDEF);
        drive_item(xoshiro_pkg::CMD_SEED64, 64'hFEDC_BA98_7654_3210);
        drive_item(xoshiro_pkg::CMD_DRAW, 64'd0);
        drive_item(xoshiro_pkg::CMD_DRAW, 64'd0);

        // Random part: mostly draws, with seeds and the odd ignored item mixed in.
        produced = 0;
        while (produced < RANDOM_ITEMS) begin
            if (produced >= RANDOM_ITEMS - QUIET_ITEMS) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else if (produced % 50 == 0) begin
                case ($urandom_range(0, 2))
                    0: tx_idle_pct = 0;
                    1: tx_idle_pct = 15;
                    default: tx_idle_pct = 50;
                endcase
                case ($urandom_range(0, 2))
                    0: rx_idle_pct = 0;
                    1: rx_idle_pct = 15;
                    default: rx_idle_pct = 50;
                endcase
            end
            case ($urandom_range(0, 9))
                0: seed = 64'd0;
                1: seed = 64'hFFFF_FFFF_FFFF_FFFF;
                2: seed = 64'd1 << $urandom_range(0, 63);
                default: seed = {$urandom, $urandom};
            endcase
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                cmd = xoshiro_pkg::CMD_DRAW;
            end else if (pick < 88) begin
                cmd = xoshiro_pkg::CMD_SEED32;
            end else if (pick < 96) begin
                cmd = xoshiro_pkg::CMD_SEED64;
            end else begin
                cmd = CMD_UNUSED;
            end
            drive_item(cmd, seed);
            if (cmd != CMD_UNUSED) begin
                produced++;
            end
        end
        s_tvalid <= 1'b0;

        // Drain: every expected word must arrive, then nothing more.
        while (sb.pending_words.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Run covered %0d draws, %0d narrow seeds, %0d wide seeds, %0d ignored items.",
                 sb.draws, sb.seeds32, sb.seeds64, sb.ignored);
        $display("%0d words checked, %0d mismatches.", sb.words_checked, sb.errors);
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
